FILE: design/ssr_pkg.sv
// Package with the shared types, constants, microcode table and saturation helper.
package ssr_pkg;

   localparam int MAX_SLOTS = 24;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int Z_W       = 32;
   localparam int LEN_W     = 24;
   localparam int DT_W      = 16;
   localparam int DZ_W      = 24;
   localparam int PC_W      = 4;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_DATA_W = 168;

   localparam logic signed [Z_W-1:0] START_Z       = -32'sd51200;
   localparam logic signed [Z_W-1:0] DEFAULT_LIMIT = 32'sd358400;

   localparam logic signed [Z_W+1:0] Z_MAX_WIDE = 34'sd2147483647;
   localparam logic signed [Z_W+1:0] Z_MIN_WIDE = -34'sd2147483648;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_SLOTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT = 2'd3;

   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_TICK    = 1'b1;
   localparam logic KIND_RECYCLE = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_WAIT,
      DP_RESTART_INIT,
      DP_LAYOUT,
      DP_TICK_INIT,
      DP_MOVE,
      DP_ADVANCE,
      DP_SCAN_INIT,
      DP_SCAN,
      DP_EMIT_RECYCLE,
      DP_EMIT_SUMMARY
   } dp_op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_WAIT_REQ,
      C_TICK,
      C_I_MORE,
      C_J_MORE,
      C_DT_ZERO,
      C_OVER
   } cond_type;

   typedef struct packed {
      dp_op_type        op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
      logic             take_req;
      logic             emit;
   } ucode_type;

   // Program addresses.
   localparam logic [PC_W-1:0] A_IDLE       = 4'd0;
   localparam logic [PC_W-1:0] A_DISPATCH   = 4'd1;
   localparam logic [PC_W-1:0] A_RST_INIT   = 4'd2;
   localparam logic [PC_W-1:0] A_LAYOUT     = 4'd3;
   localparam logic [PC_W-1:0] A_RST_DONE   = 4'd4;
   localparam logic [PC_W-1:0] A_TICK_INIT  = 4'd5;
   localparam logic [PC_W-1:0] A_MOVE       = 4'd6;
   localparam logic [PC_W-1:0] A_ADVANCE    = 4'd7;
   localparam logic [PC_W-1:0] A_SUM_START  = 4'd8;
   localparam logic [PC_W-1:0] A_SUM_SCAN   = 4'd9;
   localparam logic [PC_W-1:0] A_SUM_EMIT   = 4'd10;
   localparam logic [PC_W-1:0] A_REC_START  = 4'd11;
   localparam logic [PC_W-1:0] A_REC_SCAN   = 4'd12;
   localparam logic [PC_W-1:0] A_REC_EMIT   = 4'd13;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      w = '{op: DP_NONE, cond: C_NEXT, target: A_IDLE, take_req: 1'b0, emit: 1'b0};
      unique case (addr)
         A_IDLE: begin
            w = '{op: DP_WAIT, cond: C_WAIT_REQ, target: A_IDLE, take_req: 1'b1, emit: 1'b0};
         end
         A_DISPATCH: begin
            w = '{op: DP_NONE, cond: C_TICK, target: A_TICK_INIT, take_req: 1'b0, emit: 1'b0};
         end
         A_RST_INIT: begin
            w = '{op: DP_RESTART_INIT, cond: C_NEXT, target: A_IDLE, take_req: 1'b0, emit: 1'b0};
         end
         A_LAYOUT: begin
            w = '{op: DP_LAYOUT, cond: C_I_MORE, target: A_LAYOUT, take_req: 1'b0, emit: 1'b0};
         end
         A_RST_DONE: begin
            w = '{op: DP_NONE, cond: C_ALWAYS, target: A_SUM_START, take_req: 1'b0, emit: 1'b0};
         end
         A_TICK_INIT: begin
            w = '{op: DP_TICK_INIT, cond: C_DT_ZERO, target: A_SUM_START, take_req: 1'b0,
                  emit: 1'b0};
         end
         A_MOVE: begin
            w = '{op: DP_MOVE, cond: C_OVER, target: A_REC_START, take_req: 1'b0, emit: 1'b0};
         end
         A_ADVANCE: begin
            w = '{op: DP_ADVANCE, cond: C_I_MORE, target: A_MOVE, take_req: 1'b0, emit: 1'b0};
         end
         A_SUM_START: begin
            w = '{op: DP_SCAN_INIT, cond: C_NEXT, target: A_IDLE, take_req: 1'b0, emit: 1'b0};
         end
         A_SUM_SCAN: begin
            w = '{op: DP_SCAN, cond: C_J_MORE, target: A_SUM_SCAN, take_req: 1'b0, emit: 1'b0};
         end
         A_SUM_EMIT: begin
            w = '{op: DP_EMIT_SUMMARY, cond: C_ALWAYS, target: A_IDLE, take_req: 1'b0,
                  emit: 1'b1};
         end
         A_REC_START: begin
            w = '{op: DP_SCAN_INIT, cond: C_NEXT, target: A_IDLE, take_req: 1'b0, emit: 1'b0};
         end
         A_REC_SCAN: begin
            w = '{op: DP_SCAN, cond: C_J_MORE, target: A_REC_SCAN, take_req: 1'b0, emit: 1'b0};
         end
         A_REC_EMIT: begin
            w = '{op: DP_EMIT_RECYCLE, cond: C_ALWAYS, target: A_ADVANCE, take_req: 1'b0,
                  emit: 1'b1};
         end
         default: begin
            w = '{op: DP_NONE, cond: C_ALWAYS, target: A_IDLE, take_req: 1'b0, emit: 1'b0};
         end
      endcase
      return w;
   endfunction

   // Clamp a widened sum back into the signed Z range.
   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [Z_W+1:0] v);
      logic signed [Z_W-1:0] r;
      if (v > Z_MAX_WIDE) begin
         r = Z_MAX_WIDE[Z_W-1:0];
      end else if (v < Z_MIN_WIDE) begin
         r = Z_MIN_WIDE[Z_W-1:0];
      end else begin
         r = v[Z_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: design/scrolling_segment_recycler_unit.sv
// Segment recycler: microcoded sequencer driving the slot Z datapath.
// A restart lays out the active slots; a tick moves each active slot and recycles each
// slot that passes the limit; both end with a summary. One slot read port serves the
// move pass and the minimum/maximum scans. One item is worked at a time; the next is
// taken while the last result waits in the output register. Synchronous active-high
// reset clears slots, counters, sequencer and output valid, and sets config defaults.
module scrolling_segment_recycler_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ssr_pkg::DT_W-1:0]          req_tdata,   // delta_time[15:0]
   input  logic                              req_tuser,   // cmd
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot_index[4:0], new_id[36:5], new_z[68:37], total_recycled[100:69],
   // lowest_z[132:101], highest_z[164:133], zero fill[167:165]
   output logic [ssr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,   // kind
   output logic                              rsp_tlast,   // final_flag
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_data
);
   import ssr_pkg::*;

   // Configuration registers.
   logic [SLOT_W-1:0]        cfg_slots_ff;
   logic [LEN_W-1:0]         cfg_speed_ff;
   logic [LEN_W-1:0]         cfg_len_ff;
   logic signed [Z_W-1:0]    cfg_limit_ff;

   // Sequencer and datapath state.
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic                     cmd_ff, cmd_in;
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic [SLOT_W-1:0]        i_ff, i_in;
   logic [SLOT_W-1:0]        j_ff, j_in;
   logic signed [Z_W-1:0]    zacc_ff, zacc_in;
   logic [DZ_W-1:0]          dz_ff, dz_in;
   logic signed [Z_W-1:0]    min_ff, min_in;
   logic signed [Z_W-1:0]    max_ff, max_in;
   logic [31:0]              id_ff, id_in;
   logic [31:0]              total_ff, total_in;
   logic signed [Z_W-1:0]    slot_z_ff [MAX_SLOTS];

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff;
   logic                     rsp_last_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic                     rsp_load;
   logic                     rsp_kind_new;
   logic [RSP_DATA_W-1:0]    rsp_data_new;

   ucode_type                uc;
   logic                     go;
   logic                     taken;
   logic                     req_accept;
   logic [CNT_W-1:0]         n_active;
   logic                     i_more;
   logic                     j_more;
   logic                     over;
   logic signed [Z_W-1:0]    limit_eff;
   logic [SLOT_W-1:0]        rd_addr;
   logic signed [Z_W-1:0]    rd_z;
   logic signed [Z_W-1:0]    z_move;
   logic signed [Z_W-1:0]    z_layout_next;
   logic signed [Z_W-1:0]    z_rec;
   logic [LEN_W+DT_W-1:0]    product;
   logic                     wr_en;
   logic signed [Z_W-1:0]    wr_data;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign uc         = ucode_rom(pc_ff);
   assign go         = !(uc.emit && rsp_valid_ff && !rsp_tready);
   assign req_tready = uc.take_req;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (cfg_slots_ff == '0) begin
         n_active = CNT_W'(1);
      end else if (CNT_W'(cfg_slots_ff) > CNT_W'(MAX_SLOTS)) begin
         n_active = CNT_W'(MAX_SLOTS);
      end else begin
         n_active = CNT_W'(cfg_slots_ff);
      end
   end

   assign limit_eff = (cfg_limit_ff == '0) ? DEFAULT_LIMIT : cfg_limit_ff;
   assign i_more    = (CNT_W'(i_ff) + CNT_W'(1)) < n_active;
   assign j_more    = (CNT_W'(j_ff) + CNT_W'(1)) < n_active;

   // Single read port: scans walk j, everything else works on slot i.
   assign rd_addr = (uc.op == DP_SCAN) ? j_ff : i_ff;
   assign rd_z    = slot_z_ff[rd_addr];

   assign product       = (LEN_W+DT_W)'(cfg_speed_ff) * (LEN_W+DT_W)'(dt_ff);
   assign z_move        = sat_z((Z_W+2)'(rd_z) + $signed({10'b0, dz_ff}));
   assign z_layout_next = sat_z((Z_W+2)'(zacc_ff) - $signed({10'b0, cfg_len_ff}));
   assign z_rec         = sat_z((Z_W+2)'(min_ff) - $signed({10'b0, cfg_len_ff}));
   assign over          = z_move > limit_eff;

   // Next step of the program.
   always_comb begin
      unique case (uc.cond)
         C_NEXT:     taken = 1'b0;
         C_ALWAYS:   taken = 1'b1;
         C_WAIT_REQ: taken = !req_accept;
         C_TICK:     taken = (cmd_ff == CMD_TICK);
         C_I_MORE:   taken = i_more;
         C_J_MORE:   taken = j_more;
         C_DT_ZERO:  taken = (dt_ff == '0);
         C_OVER:     taken = over;
         default:    taken = 1'b0;
      endcase
      if (!go) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = uc.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   // Datapath actions selected by the control word.
   always_comb begin
      cmd_in       = cmd_ff;
      dt_in        = dt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      zacc_in      = zacc_ff;
      dz_in        = dz_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      id_in        = id_ff;
      total_in     = total_ff;
      wr_en        = 1'b0;
      wr_data      = z_move;
      rsp_load     = 1'b0;
      rsp_kind_new = KIND_SUMMARY;
      rsp_data_new = '0;
      unique case (uc.op)
         DP_WAIT: begin
            if (req_accept) begin
               cmd_in = req_tuser;
               dt_in  = req_tdata;
            end
         end
         DP_RESTART_INIT: begin
            id_in    = '0;
            total_in = '0;
            i_in     = '0;
            zacc_in  = START_Z;
         end
         DP_LAYOUT: begin
            wr_en   = 1'b1;
            wr_data = zacc_ff;
            zacc_in = z_layout_next;
            id_in   = id_ff + 32'd1;
            i_in    = i_ff + SLOT_W'(1);
         end
         DP_TICK_INIT: begin
            dz_in = product[LEN_W+DT_W-1:DT_W];
            i_in  = '0;
         end
         DP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = z_move;
         end
         DP_ADVANCE: begin
            i_in = i_ff + SLOT_W'(1);
         end
         DP_SCAN_INIT: begin
            j_in = '0;
         end
         DP_SCAN: begin
            if (j_ff == '0) begin
               min_in = rd_z;
               max_in = rd_z;
            end else begin
               if (rd_z < min_ff) min_in = rd_z;
               if (rd_z > max_ff) max_in = rd_z;
            end
            j_in = j_ff + SLOT_W'(1);
         end
         DP_EMIT_RECYCLE: begin
            if (go) begin
               wr_en        = 1'b1;
               wr_data      = z_rec;
               id_in        = id_ff + 32'd1;
               total_in     = total_ff + 32'd1;
               rsp_load     = 1'b1;
               rsp_kind_new = KIND_RECYCLE;
               rsp_data_new = {3'b0, 32'd0, 32'd0, 32'd0, z_rec, id_ff, i_ff};
            end
         end
         DP_EMIT_SUMMARY: begin
            if (go) begin
               rsp_load     = 1'b1;
               rsp_kind_new = KIND_SUMMARY;
               rsp_data_new = {3'b0, max_ff, min_ff, total_ff, 32'd0, 32'd0, 5'd0};
            end
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= A_IDLE;
         rsp_valid_ff <= 1'b0;
         id_ff        <= '0;
         total_ff     <= '0;
         cfg_slots_ff <= SLOT_W'(MAX_SLOTS);
         cfg_speed_ff <= '0;
         cfg_len_ff   <= '0;
         cfg_limit_ff <= DEFAULT_LIMIT;
         for (int k = 0; k < MAX_SLOTS; k++) begin
            slot_z_ff[k] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         id_ff        <= id_in;
         total_ff     <= total_in;
         if (wr_en) begin
            slot_z_ff[i_ff] <= wr_data;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_SLOTS: cfg_slots_ff <= csr_data[SLOT_W-1:0];
               REG_SPEED: cfg_speed_ff <= csr_data[LEN_W-1:0];
               REG_LEN:   cfg_len_ff   <= csr_data[LEN_W-1:0];
               REG_LIMIT: cfg_limit_ff <= $signed(csr_data);
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      dt_ff   <= dt_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      zacc_ff <= zacc_in;
      dz_ff   <= dz_in;
      min_ff  <= min_in;
      max_ff  <= max_in;
      if (rsp_load) begin
         rsp_kind_ff <= rsp_kind_new;
         rsp_last_ff <= (rsp_kind_new == KIND_SUMMARY);
         rsp_data_ff <= rsp_data_new;
      end
   end

`ifndef NO_ASSERTIONS
   // Slot writes stay inside the active part of the ring.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(i_ff) < n_active))
      else $error("slot write beyond active slot count");

   // Scans read only active slots.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (uc.op == DP_SCAN) |-> (CNT_W'(j_ff) < n_active))
      else $error("scan read beyond active slot count");

   // An accepted transaction is always followed by the dispatch step.
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (pc_ff == A_DISPATCH))
      else $error("accepted transaction did not reach dispatch");

   // A summary never reports a minimum above its maximum.
   a_summary_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_SUMMARY) |->
         ($signed(rsp_data_ff[132:101]) <= $signed(rsp_data_ff[164:133])))
      else $error("summary minimum above maximum");
`endif

endmodule
